// ===== rtl/sia_pkg.sv =====
// Shared types and operation codes for the signed integer ALU.
package sia_pkg;

   // Operation codes carried in the request tuser
   typedef enum logic [2:0] {
      MODE_ADD  = 3'd0,
      MODE_SUB  = 3'd1,
      MODE_MUL  = 3'd2,
      MODE_DIV  = 3'd3,
      MODE_CMP  = 3'd4,
      MODE_NEG  = 3'd5,
      MODE_SIGN = 3'd6
   } mode_type;

   localparam int MODE_WIDTH = 3;

   // Control that rides along with every beat through the cell chain
   typedef struct packed {
      mode_type mode;
      logic     qneg;   // quotient takes a negative sign
      logic     dz;     // division by zero seen
   } ctl_type;

endpackage

// ===== rtl/sia_front.sv =====
// Front stage: decodes the operation, forms magnitudes and the one-adder results.
module sia_front #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [sia_pkg::MODE_WIDTH-1:0] in_mode,
   input  logic [DATA_WIDTH-1:0]          in_a,
   input  logic [DATA_WIDTH-1:0]          in_b,
   output logic                           out_valid,
   input  logic                           out_ready,
   output sia_pkg::ctl_type               out_ctl,
   output logic [DATA_WIDTH-1:0]          out_acc,
   output logic [DATA_WIDTH-1:0]          out_mcand,
   output logic [DATA_WIDTH-1:0]          out_mplier,
   output logic [DATA_WIDTH-1:0]          out_quo,
   output logic [DATA_WIDTH-1:0]          out_mb
);

   localparam int W = DATA_WIDTH;

   logic             valid_ff;
   sia_pkg::ctl_type ctl_ff, ctl_in;
   logic [W-1:0]     acc_ff, acc_in;
   logic [W-1:0]     mcand_ff, mplier_ff, quo_ff, mb_ff;
   logic [W-1:0]     ma, mb;
   logic [W-1:0]     add_x, add_y;
   logic             add_c;
   logic [W-1:0]     add_sum;
   logic             load;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   // Form operand magnitudes for division
   assign ma = in_a[W-1] ? (~in_a + W'(1)) : in_a;
   assign mb = in_b[W-1] ? (~in_b + W'(1)) : in_b;

   // Share one adder for add, subtract, compare and negate
   always_comb begin
      add_x = in_a;
      add_y = ~in_b;
      add_c = 1'b1;
      unique case (sia_pkg::mode_type'(in_mode))
         sia_pkg::MODE_ADD: begin
            add_y = in_b;
            add_c = 1'b0;
         end
         sia_pkg::MODE_NEG: begin
            add_x = '0;
            add_y = ~in_a;
         end
         default: begin
            add_x = in_a;
         end
      endcase
   end

   assign add_sum = add_x + add_y + W'(add_c);

   // Pick the value that rides in the accumulator
   always_comb begin
      ctl_in.mode = sia_pkg::mode_type'(in_mode);
      ctl_in.qneg = in_a[W-1] ^ in_b[W-1];
      ctl_in.dz   = 1'b0;
      acc_in      = '0;
      case (sia_pkg::mode_type'(in_mode)) inside
         sia_pkg::MODE_ADD, sia_pkg::MODE_SUB, sia_pkg::MODE_CMP, sia_pkg::MODE_NEG: begin
            acc_in = add_sum;
         end
         sia_pkg::MODE_SIGN: begin
            acc_in = {{(W-1){1'b0}}, in_a[W-1]};
         end
         sia_pkg::MODE_DIV: begin
            ctl_in.dz = (in_b == '0);
         end
         default: begin
            acc_in = '0;
         end
      endcase
   end

   // Hold the control flag of the stage
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   // Load the payload on an accepted beat
   always_ff @(posedge clock) begin
      if (load) begin
         ctl_ff    <= ctl_in;
         acc_ff    <= acc_in;
         mcand_ff  <= in_a;
         mplier_ff <= in_b;
         quo_ff    <= ma;
         mb_ff     <= mb;
      end
   end

   assign out_valid  = valid_ff;
   assign out_ctl    = ctl_ff;
   assign out_acc    = acc_ff;
   assign out_mcand  = mcand_ff;
   assign out_mplier = mplier_ff;
   assign out_quo    = quo_ff;
   assign out_mb     = mb_ff;

endmodule

// ===== rtl/sia_cell.sv =====
// One cell of the chain: one quotient bit and one multiply partial product.
module sia_cell #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  sia_pkg::ctl_type       in_ctl,
   input  logic [DATA_WIDTH-1:0]  in_acc,
   input  logic [DATA_WIDTH-1:0]  in_mcand,
   input  logic [DATA_WIDTH-1:0]  in_mplier,
   input  logic [DATA_WIDTH-1:0]  in_rem,
   input  logic [DATA_WIDTH-1:0]  in_quo,
   input  logic [DATA_WIDTH-1:0]  in_mb,
   output logic                   out_valid,
   input  logic                   out_ready,
   output sia_pkg::ctl_type       out_ctl,
   output logic [DATA_WIDTH-1:0]  out_acc,
   output logic [DATA_WIDTH-1:0]  out_mcand,
   output logic [DATA_WIDTH-1:0]  out_mplier,
   output logic [DATA_WIDTH-1:0]  out_rem,
   output logic [DATA_WIDTH-1:0]  out_quo,
   output logic [DATA_WIDTH-1:0]  out_mb
);

   localparam int W = DATA_WIDTH;

   logic             valid_ff;
   sia_pkg::ctl_type ctl_ff;
   logic [W-1:0]     acc_ff, acc_in;
   logic [W-1:0]     mcand_ff, mplier_ff, rem_ff, rem_in, quo_ff, mb_ff;
   logic [W-1:0]     shifted;
   logic [W:0]       trial;
   logic             take;
   logic             load;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   // Try one restoring subtract step
   assign shifted = {in_rem[W-2:0], in_quo[W-1]};
   assign trial   = {1'b0, shifted} - {1'b0, in_mb};
   assign take    = !trial[W];
   assign rem_in  = take ? trial[W-1:0] : shifted;

   // Add the partial product when multiplying
   always_comb begin
      acc_in = in_acc;
      if (in_ctl.mode == sia_pkg::MODE_MUL && in_mplier[0]) begin
         acc_in = in_acc + in_mcand;
      end
   end

   // Hold the control flag of the cell
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   // Advance the payload to the next cell
   always_ff @(posedge clock) begin
      if (load) begin
         ctl_ff    <= in_ctl;
         acc_ff    <= acc_in;
         mcand_ff  <= {in_mcand[W-2:0], 1'b0};
         mplier_ff <= {1'b0, in_mplier[W-1:1]};
         rem_ff    <= rem_in;
         quo_ff    <= {in_quo[W-2:0], take};
         mb_ff     <= in_mb;
      end
   end

   assign out_valid  = valid_ff;
   assign out_ctl    = ctl_ff;
   assign out_acc    = acc_ff;
   assign out_mcand  = mcand_ff;
   assign out_mplier = mplier_ff;
   assign out_rem    = rem_ff;
   assign out_quo    = quo_ff;
   assign out_mb     = mb_ff;

endmodule

// ===== rtl/sia_back.sv =====
// Back stage: signs the quotient, selects the result and holds the output beat.
module sia_back #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  sia_pkg::ctl_type       in_ctl,
   input  logic [DATA_WIDTH-1:0]  in_acc,
   input  logic [DATA_WIDTH-1:0]  in_rem,
   input  logic [DATA_WIDTH-1:0]  in_quo,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [DATA_WIDTH-1:0]  out_value,
   output logic [DATA_WIDTH-2:0]  out_rem,
   output logic                   out_dz
);

   localparam int W = DATA_WIDTH;

   logic         valid_ff;
   logic [W-1:0] value_ff, value_in;
   logic [W-2:0] rem_ff, rem_in;
   logic         dz_ff;
   logic         load;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   // Select the result of the operation
   always_comb begin
      value_in = in_acc;
      rem_in   = '0;
      if (in_ctl.mode == sia_pkg::MODE_DIV) begin
         if (in_ctl.dz) begin
            value_in = '0;
         end else begin
            value_in = in_ctl.qneg ? (~in_quo + W'(1)) : in_quo;
            rem_in   = in_rem[W-2:0];
         end
      end
   end

   // Hold the output flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   // Load the result beat
   always_ff @(posedge clock) begin
      if (load) begin
         value_ff <= value_in;
         rem_ff   <= rem_in;
         dz_ff    <= in_ctl.dz;
      end
   end

   assign out_valid = valid_ff;
   assign out_value = value_ff;
   assign out_rem   = rem_ff;
   assign out_dz    = dz_ff;

endmodule

// ===== rtl/signed_integer_alu.sv =====
// Signed integer ALU: front stage, a chain of DATA_WIDTH cells and an output stage.
// A request beat is registered in the front stage, in every cell and in the output stage.
// Throughput is one beat per cycle while rsp_tready does not stall; each cell handles one quotient bit and one
// multiply partial product, so every operation runs through the full chain.
// Reset clears every stage's valid flag; payload registers are not reset.
module signed_integer_alu #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   // operand_a, operand_b, zero padding
   input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]         req_tdata,
   // mode
   input  logic [sia_pkg::MODE_WIDTH-1:0]            req_tuser,
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   // value_out, remainder_out, zero padding
   output logic [((2*DATA_WIDTH-1+7)/8)*8-1:0]       rsp_tdata,
   // divide_by_zero
   output logic                                      rsp_tuser
);

   localparam int W         = DATA_WIDTH;
   localparam int RSP_WIDTH = ((2*W-1+7)/8)*8;

   logic                 valid_s  [0:W];
   logic                 ready_s  [0:W];
   sia_pkg::ctl_type     ctl_s    [0:W];
   logic [W-1:0]         acc_s    [0:W];
   logic [W-1:0]         mcand_s  [0:W];
   logic [W-1:0]         mplier_s [0:W];
   logic [W-1:0]         rem_s    [0:W];
   logic [W-1:0]         quo_s    [0:W];
   logic [W-1:0]         mb_s     [0:W];
   logic [W-1:0]         value;
   logic [W-2:0]         rem;

   // Decode and prepare operands
   sia_front #(.DATA_WIDTH(W)) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_mode    (req_tuser),
      .in_a       (req_tdata[W-1:0]),
      .in_b       (req_tdata[2*W-1:W]),
      .out_valid  (valid_s[0]),
      .out_ready  (ready_s[0]),
      .out_ctl    (ctl_s[0]),
      .out_acc    (acc_s[0]),
      .out_mcand  (mcand_s[0]),
      .out_mplier (mplier_s[0]),
      .out_quo    (quo_s[0]),
      .out_mb     (mb_s[0])
   );

   assign rem_s[0] = '0;

   // Chain the cells
   for (genvar i = 0; i < W; i++) begin : g_cell
      sia_cell #(.DATA_WIDTH(W)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .in_valid   (valid_s[i]),
         .in_ready   (ready_s[i]),
         .in_ctl     (ctl_s[i]),
         .in_acc     (acc_s[i]),
         .in_mcand   (mcand_s[i]),
         .in_mplier  (mplier_s[i]),
         .in_rem     (rem_s[i]),
         .in_quo     (quo_s[i]),
         .in_mb      (mb_s[i]),
         .out_valid  (valid_s[i+1]),
         .out_ready  (ready_s[i+1]),
         .out_ctl    (ctl_s[i+1]),
         .out_acc    (acc_s[i+1]),
         .out_mcand  (mcand_s[i+1]),
         .out_mplier (mplier_s[i+1]),
         .out_rem    (rem_s[i+1]),
         .out_quo    (quo_s[i+1]),
         .out_mb     (mb_s[i+1])
      );
   end

   // Finish and hold the result
   sia_back #(.DATA_WIDTH(W)) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid_s[W]),
      .in_ready  (ready_s[W]),
      .in_ctl    (ctl_s[W]),
      .in_acc    (acc_s[W]),
      .in_rem    (rem_s[W]),
      .in_quo    (quo_s[W]),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_value (value),
      .out_rem   (rem),
      .out_dz    (rsp_tuser)
   );

   // Pack the response beat
   assign rsp_tdata = RSP_WIDTH'({rem, value});

endmodule
